// ===== rtl/gccd_pkg.sv =====
package gccd_pkg;

   // payload layout of one normal burst
   localparam int PAY_LEN       = 57;
   localparam int PAY_PER_BURST = 2 * PAY_LEN;
   localparam int FIRST_LO      = 3;
   localparam int SECOND_LO     = 88;
   localparam int STEP_MUL      = 49;
   localparam int BURSTS        = 4;
   localparam int CODED_LEN     = BURSTS * PAY_PER_BURST;
   localparam int NUM_WORDS     = CODED_LEN / PAY_LEN;

   localparam int FRAME_W = 22;
   localparam int POS_W   = 8;
   localparam int HELD_W  = $clog2(BURSTS);
   localparam int ADDR_W  = $clog2(CODED_LEN);
   localparam int MOD_W   = $clog2(PAY_LEN);
   localparam int IDX_W   = $clog2(NUM_WORDS);
   localparam int PHASE_W = $clog2(2 * BURSTS);

   // result kinds
   localparam logic [1:0] ST_DATA   = 2'd0;
   localparam logic [1:0] ST_GAP    = 2'd1;
   localparam logic [1:0] ST_OFFSET = 2'd2;

   // one write into the payload store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic              data;
   } wr_type;

   // per-transfer events from the burst checker
   typedef struct packed {
      logic               drop;
      logic [1:0]         code;
      logic               done;
      logic [FRAME_W-1:0] first_frame;
   } evt_type;

   // start of a burst's payload area in the store
   function automatic logic [ADDR_W-1:0] burst_base(input logic [HELD_W-1:0] burst);
      return ADDR_W'(burst) * ADDR_W'(PAY_PER_BURST);
   endfunction

endpackage

// ===== rtl/gsm_ccch_burst_deinterleaver_unit.sv =====
// a burst bit causes no result unless it completes a block or fails a check
// a failed check reports one result in the cycle after the transfer
// a completing bit starts the readout of the 57-bit words, bound by one store read a cycle
// a word waits in the emit state while the output stalls; no input is taken until the readout ends
// synchronous active-high reset clears the front counters, the sequencer state and flags; store contents stay undefined
module gsm_ccch_burst_deinterleaver_unit
   import gccd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // tdma_frame[21:0], slot_offset[23:22], burst_bit[24]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // word_index[2:0], coded_bits[59:3], block_frame[81:60]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   wr_type              wr;
   evt_type             evt;
   logic                core_ready;
   logic                take;
   logic [IDX_W-1:0]    rsp_index;
   logic [PAY_LEN-1:0]  rsp_bits;
   logic [FRAME_W-1:0]  rsp_frame;

   assign req_tready = core_ready;
   assign take       = req_tvalid && core_ready;

   gccd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .tdma_frame   (req_tdata[21:0]),
      .slot_offset  (req_tdata[23:22]),
      .burst_bit    (req_tdata[24]),
      .bit_last     (req_tlast),
      .wr           (wr),
      .evt          (evt)
   );

   gccd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .evt        (evt),
      .ready      (core_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_index  (rsp_index),
      .rsp_bits   (rsp_bits),
      .rsp_frame  (rsp_frame),
      .rsp_last   (rsp_tlast)
   );

   // result transfer packing
   assign rsp_tdata = {6'd0, rsp_frame, rsp_bits, rsp_index};

endmodule

// ===== rtl/gccd_front.sv =====
module gccd_front
   import gccd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [FRAME_W-1:0] tdma_frame,
   input  logic [1:0]         slot_offset,
   input  logic               burst_bit,
   input  logic               bit_last,
   output wr_type             wr,
   output evt_type            evt
);

   localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};
   localparam logic [POS_W-1:0]  LO_A       = POS_W'(FIRST_LO);
   localparam logic [POS_W-1:0]  HI_A       = POS_W'(FIRST_LO + PAY_LEN);
   localparam logic [POS_W-1:0]  LO_B       = POS_W'(SECOND_LO);
   localparam logic [POS_W-1:0]  HI_B       = POS_W'(SECOND_LO + PAY_LEN);
   localparam logic [ADDR_W-1:0] SHIFT_B    = ADDR_W'(SECOND_LO - PAY_LEN);
   localparam logic [HELD_W-1:0] HELD_LAST  = HELD_W'(BURSTS - 1);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [HELD_W-1:0]  held_ff, held_in;
   logic [FRAME_W-1:0] prev_ff, prev_in;
   logic [FRAME_W-1:0] first_ff, first_in;
   logic               drop_ff, drop_in;

   logic               start;
   logic               gap_fail;
   logic               off_fail;
   logic               dropping;
   logic [ADDR_W-1:0]  base;

   // burst header checks at the first bit
   assign start    = (pos_ff == '0);
   assign gap_fail = start && (held_ff != '0) &&
                     (({1'b0, prev_ff} + (FRAME_W+1)'(1)) != {1'b0, tdma_frame});
   assign off_fail = start && !gap_fail && (slot_offset != held_ff);
   assign dropping = start ? (gap_fail || off_fail) : drop_ff;
   assign base     = burst_base(held_ff);

   // payload write address
   always_comb begin
      wr.en   = 1'b0;
      wr.addr = base;
      wr.data = burst_bit;
      if (take && !dropping) begin
         if (pos_ff >= LO_A && pos_ff < HI_A) begin
            wr.en   = 1'b1;
            wr.addr = base + ADDR_W'(pos_ff) - ADDR_W'(FIRST_LO);
         end else if (pos_ff >= LO_B && pos_ff < HI_B) begin
            wr.en   = 1'b1;
            wr.addr = base + ADDR_W'(pos_ff) - SHIFT_B;
         end
      end
   end

   // events for the readout side
   always_comb begin
      evt.drop        = take && (gap_fail || off_fail);
      evt.code        = gap_fail ? ST_GAP : ST_OFFSET;
      evt.done        = take && bit_last && !dropping && (held_ff == HELD_LAST);
      evt.first_frame = first_ff;
   end

   // burst bookkeeping
   always_comb begin
      pos_in   = pos_ff;
      held_in  = held_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      drop_in  = drop_ff;
      if (take) begin
         if (start) begin
            if (gap_fail || off_fail) begin
               held_in = '0;
               drop_in = 1'b1;
            end else begin
               drop_in = 1'b0;
               prev_in = tdma_frame;
               if (held_ff == '0) begin
                  first_in = tdma_frame;
               end
            end
         end
         if (bit_last) begin
            pos_in  = '0;
            drop_in = 1'b0;
            if (!dropping) begin
               held_in = held_ff + HELD_W'(1);
            end
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         held_ff  <= '0;
         prev_ff  <= '0;
         first_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         prev_ff  <= prev_in;
         first_ff <= first_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ===== rtl/gccd_core.sv =====
module gccd_core
   import gccd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  wr_type              wr,
   input  evt_type             evt,
   output logic                ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [IDX_W-1:0]    rsp_index,
   output logic [PAY_LEN-1:0]  rsp_bits,
   output logic [FRAME_W-1:0]  rsp_frame,
   output logic                rsp_last
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   localparam logic [MOD_W-1:0] BIT_LAST  = MOD_W'(PAY_LEN - 1);
   localparam logic [IDX_W-1:0] WORD_LAST = IDX_W'(NUM_WORDS - 1);

   logic                mem [CODED_LEN];
   logic                rd_data_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;

   logic [1:0]          state_ff, state_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [MOD_W-1:0]    m_ff, m_in;
   logic [MOD_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    w_ff, w_in;
   logic                pend_ff;
   logic [PAY_LEN-1:0]  shift_ff;
   logic [FRAME_W-1:0]  bf_ff, bf_in;

   logic                out_valid_ff, out_valid_in;
   logic [1:0]          out_status_ff, out_status_in;
   logic [IDX_W-1:0]    out_index_ff, out_index_in;
   logic [PAY_LEN-1:0]  out_bits_ff, out_bits_in;
   logic [FRAME_W-1:0]  out_frame_ff, out_frame_in;
   logic                out_last_ff, out_last_in;

   logic                out_free;
   logic [MOD_W:0]      m_sum;

   // payload store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // source address of coded bit k: burst k mod 4, index 2*(49k mod 57) + (k mod 8)/4
   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = burst_base(phase_ff[HELD_W-1:0]) + ADDR_W'({m_ff, 1'b0}) +
                    ADDR_W'(phase_ff[PHASE_W-1]);
   assign m_sum   = {1'b0, m_ff} + (MOD_W+1)'(STEP_MUL);

   assign out_free = !out_valid_ff || rsp_ready;
   assign ready    = (state_ff == S_IDLE) && out_free;

   // readout sequencer and output register
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      m_in          = m_ff;
      i_in          = i_ff;
      w_in          = w_ff;
      bf_in         = bf_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_bits_in   = out_bits_ff;
      out_frame_in  = out_frame_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (evt.done) begin
               state_in = S_READ;
               phase_in = '0;
               m_in     = '0;
               i_in     = '0;
               w_in     = '0;
               bf_in    = evt.first_frame;
            end else if (evt.drop) begin
               out_valid_in  = 1'b1;
               out_status_in = evt.code;
               out_index_in  = '0;
               out_bits_in   = '0;
               out_frame_in  = '0;
               out_last_in   = 1'b1;
            end
         end
         S_READ: begin
            phase_in = phase_ff + PHASE_W'(1);
            m_in     = (m_sum >= (MOD_W+1)'(PAY_LEN)) ?
                       MOD_W'(m_sum - (MOD_W+1)'(PAY_LEN)) : MOD_W'(m_sum);
            if (i_ff == BIT_LAST) begin
               i_in     = '0;
               state_in = S_DRAIN;
            end else begin
               i_in = i_ff + MOD_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_DATA;
               out_index_in  = w_ff;
               out_bits_in   = shift_ff;
               out_frame_in  = bf_ff;
               out_last_in   = (w_ff == WORD_LAST);
               if (w_ff == WORD_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  w_in     = w_ff + IDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // word assembly, first read bit ends up in the lsb
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         shift_ff <= {rd_data_ff, shift_ff[PAY_LEN-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= rd_en;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      m_ff          <= m_in;
      i_ff          <= i_in;
      w_ff          <= w_in;
      bf_ff         <= bf_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_bits_ff   <= out_bits_in;
      out_frame_ff  <= out_frame_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_index  = out_index_ff;
   assign rsp_bits   = out_bits_ff;
   assign rsp_frame  = out_frame_ff;
   assign rsp_last   = out_last_ff;

   // a drop report is always a single-result run
   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != ST_DATA) |-> out_last_ff)
      else $error("drop result without run end");

   // a data run ends exactly at the last word
   a_word_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff == ST_DATA) |-> (out_last_ff == (out_index_ff == WORD_LAST)))
      else $error("data run end at wrong word");

   // reads stay inside the store
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_addr < ADDR_W'(CODED_LEN)))
      else $error("read address beyond store");

   // checker events only arrive while the sequencer is idle
   a_evt_idle: assert property (@(posedge clock) disable iff (reset)
      (evt.done || evt.drop || wr.en) |-> (state_ff == S_IDLE))
      else $error("input transfer during readout");

   // a word is loaded only after its final read has been collected
   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> $past(state_ff == S_DRAIN) || $past(state_ff == S_EMIT))
      else $error("emit without drain");

endmodule
